@@ rtl/flsa_pkg.sv @@
// Shared types, codes and default sizes for the free-list slot allocator.
`default_nettype none

package flsa_pkg;

    localparam int DEF_SLOTS        = 256;
    localparam int DEF_ELEMENT_BITS = 32;

    localparam int CMD_W    = 3;
    localparam int IDX_IN_W = 8;
    localparam int VAL_IO_W = 32;
    localparam int STAT_W   = 2;
    localparam int USED_W   = 9;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_ERASE  = 3'd1,
        CMD_READ   = 3'd2,
        CMD_WRITE  = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

endpackage

`default_nettype wire

@@ rtl/free_list_slot_allocator_unit.sv @@
// Free-list slot allocator: hands out slot indices, reuses freed slots through a linked chain.
// Erase, write, clear, mark inserts and rejected beats register their result directly; an in-range
// read and an insert taken from the free chain first pass a wait state for the RAM read.
// Stalls: no beat is taken during a wait state; the chain insert must read the head
// slot's link from the link RAM before the next insert can use the new head.
// Reset (synchronous, active low) empties the chain and zeroes the high-water mark; the RAMs
// are not cleared, no slot is readable before it has been handed out and written.
`default_nettype none

module free_list_slot_allocator_unit #(
    parameter int SLOTS        = flsa_pkg::DEF_SLOTS,
    parameter int ELEMENT_BITS = flsa_pkg::DEF_ELEMENT_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [flsa_pkg::CMD_W-1:0]     i_command,
    input  wire logic [flsa_pkg::IDX_IN_W-1:0]  i_slot_index,
    input  wire logic [flsa_pkg::VAL_IO_W-1:0]  i_value_in,
    // result channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [flsa_pkg::IDX_IN_W-1:0]  o_given_index,
    output logic      [flsa_pkg::VAL_IO_W-1:0]  o_value_out,
    output logic      [flsa_pkg::STAT_W-1:0]    o_status,
    output logic      [flsa_pkg::USED_W-1:0]    o_used_range
);

    import flsa_pkg::*;

    localparam int IDX_W  = $clog2(SLOTS);       // slot address width
    localparam int HW_W   = $clog2(SLOTS + 1);   // mark counts up to SLOTS
    localparam int LINK_W = IDX_W + 1;           // {end-of-chain, next index}

    // Sequencer: idle takes beats; the two wait states finish a RAM read.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,   // value RAM data due for a read beat
        S_LINK    // link RAM data due: new chain head after a chain insert
    } t_state;

    t_state                  r_state, n_state;
    logic [HW_W-1:0]         r_hw, n_hw;
    logic [IDX_W-1:0]        r_head, n_head;
    logic                    r_head_vld, n_head_vld;

    // Output register
    logic                    r_out_valid;
    logic [IDX_IN_W-1:0]     r_given, n_given;
    logic [VAL_IO_W-1:0]     r_value_out;
    t_status                 r_status, n_status;
    logic [USED_W-1:0]       r_used;

    // RAM ports
    logic                    val_we;
    logic [IDX_W-1:0]        val_waddr, val_raddr;
    logic [ELEMENT_BITS-1:0] val_wdata, val_rdata;
    logic                    link_we;
    logic [LINK_W-1:0]       link_wdata, link_rdata;

    logic                    fire;
    logic                    in_range;
    logic                    has_room;
    logic [IDX_W-1:0]        idx_addr;
    t_cmd                    cmd;

    // A beat is taken only when idle and the output slot is empty or draining this edge,
    // so the output register is always free by the time a wait state completes.
    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign fire       = i_in_valid && !o_in_stall;

    assign cmd      = t_cmd'(i_command);
    assign idx_addr = IDX_W'(32'(i_slot_index));
    assign in_range = 32'(i_slot_index) < 32'(r_hw);
    assign has_room = 32'(r_hw) < 32'(SLOTS);

    // Decode of the beat on the input ports; RAM writes and reads launch in the accept cycle.
    always_comb begin
        val_we     = 1'b0;
        val_waddr  = idx_addr;
        val_wdata  = ELEMENT_BITS'(i_value_in);
        val_raddr  = idx_addr;
        link_we    = 1'b0;
        // erase pushes the slot: its link is the old head, end bit when the chain was empty
        link_wdata = {~r_head_vld, r_head};
        n_given    = i_slot_index;
        n_status   = ST_OK;
        n_hw       = r_hw;
        n_head     = r_head;
        n_head_vld = r_head_vld;
        n_state    = S_IDLE;

        case (cmd)
            CMD_INSERT: begin
                if (r_head_vld) begin
                    // reuse chain head; its link is read from the link RAM at r_head
                    val_we    = fire;
                    val_waddr = r_head;
                    n_given   = IDX_IN_W'(32'(r_head));
                    n_state   = S_LINK;
                end else if (has_room) begin
                    val_we    = fire;
                    val_waddr = IDX_W'(r_hw);
                    n_given   = IDX_IN_W'(32'(r_hw));
                    n_hw      = r_hw + 1'b1;
                end else begin
                    n_status = ST_FULL;
                    n_given  = '0;
                end
            end
            CMD_ERASE: begin
                if (in_range) begin
                    val_we     = fire;
                    val_wdata  = r_head_vld ? ELEMENT_BITS'(32'(r_head)) : '1;
                    link_we    = fire;
                    n_head     = idx_addr;
                    n_head_vld = 1'b1;
                end else begin
                    n_status = ST_BAD;
                end
            end
            CMD_READ: begin
                if (in_range) begin
                    n_state = S_READ;
                end else begin
                    n_status = ST_BAD;
                end
            end
            CMD_WRITE: begin
                if (in_range) begin
                    val_we = fire;
                end else begin
                    n_status = ST_BAD;
                end
            end
            CMD_CLEAR: begin
                n_hw       = '0;
                n_head     = '0;
                n_head_vld = 1'b0;
            end
            default: begin
                // unused codes: no effect, plain ok result
            end
        endcase
    end

    // Sequencer state, chain/mark registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hw        <= '0;
            r_head      <= '0;
            r_head_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (fire) begin
                        r_state     <= n_state;
                        r_hw        <= n_hw;
                        r_head      <= n_head;
                        r_head_vld  <= n_head_vld;
                        r_given     <= n_given;
                        r_status    <= n_status;
                        r_value_out <= '0;
                        r_used      <= USED_W'(32'(n_hw));
                        r_out_valid <= (n_state == S_IDLE);
                    end else if (r_out_valid && !i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
                // output register is empty in both wait states
                S_READ: begin
                    r_value_out <= VAL_IO_W'(val_rdata);
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_LINK: begin
                    r_head      <= link_rdata[IDX_W-1:0];
                    r_head_vld  <= ~link_rdata[IDX_W];
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Slot words: element values, or the link image of a freed slot.
    flsa_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (SLOTS)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_raddr (val_raddr),
        .o_rdata (val_rdata)
    );

    // Chain links kept apart from the words so the chain is exact at any element width.
    // Read address is the current head: only a chain insert consumes the data.
    flsa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (idx_addr),
        .i_wdata (link_wdata),
        .i_raddr (r_head),
        .o_rdata (link_rdata)
    );

    assign o_out_valid   = r_out_valid;
    assign o_given_index = r_given;
    assign o_value_out   = r_value_out;
    assign o_status      = r_status;
    assign o_used_range  = r_used;

endmodule

`default_nettype wire

@@ rtl/flsa_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module flsa_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
